### rtl/core/sdnn_pkg.sv
// ----------------------------------------------------------------------------
// Subdomain node numbering: shared types and constants
// Payload structs, state encoding, sizes and the owner slot table.
// ----------------------------------------------------------------------------
package sdnn_pkg;

   localparam int MAX_DOMAINS_PER_AXIS = 8;
   localparam int LOCAL_INDEX_BITS     = 20;
   localparam int GLOBAL_INDEX_BITS    = 24;
   localparam int STORE_DEPTH          = MAX_DOMAINS_PER_AXIS * MAX_DOMAINS_PER_AXIS *
                                         MAX_DOMAINS_PER_AXIS;
   localparam int ID_BITS              = 9;
   localparam int COORD_BITS           = 3;
   localparam int CFG_BITS             = 4;
   localparam int CSR_INDEX_BITS       = 2;
   localparam int NUM_SLOTS            = 8;
   localparam int SLOT_BITS            = 3;
   // Widths of the partial products that build a subdomain id.
   localparam int NYZ_BITS             = 7;
   localparam int PX_BITS              = 10;
   localparam int PY_BITS              = 7;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DOMAINS_X = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DOMAINS_Y = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DOMAINS_Z = 2'd2;

   typedef struct packed {
      logic [COORD_BITS-1:0] dom_x;
      logic [COORD_BITS-1:0] dom_y;
      logic [COORD_BITS-1:0] dom_z;
      logic                  first_x;
      logic                  first_y;
      logic                  first_z;
   } req_payload_type;

   typedef struct packed {
      logic [ID_BITS-1:0]           domain_id;
      logic [LOCAL_INDEX_BITS-1:0]  local_index;
      logic [GLOBAL_INDEX_BITS-1:0] node_number;
      logic [GLOBAL_INDEX_BITS-1:0] interface_number;
      logic                         bad_position;
      logic                         last;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PREP,
      ST_DISPATCH
   } state_type;

   // Step back along {x, y, z} for each owner slot: own subdomain, z face,
   // y face, x face, z-y edge, y-x edge, x-z edge, corner.
   function automatic logic [2:0] slot_step(input logic [SLOT_BITS-1:0] slot);
      logic [2:0] step;
      unique case (slot)
         3'd0:    step = 3'b000;
         3'd1:    step = 3'b001;
         3'd2:    step = 3'b010;
         3'd3:    step = 3'b100;
         3'd4:    step = 3'b011;
         3'd5:    step = 3'b110;
         3'd6:    step = 3'b101;
         default: step = 3'b111;
      endcase
      return step;
   endfunction

   // Counts above the supported maximum act as the maximum.
   function automatic logic [CFG_BITS-1:0] eff_count(input logic [CFG_BITS-1:0] n);
      logic [CFG_BITS-1:0] r;
      r = (n > CFG_BITS'(MAX_DOMAINS_PER_AXIS)) ? CFG_BITS'(MAX_DOMAINS_PER_AXIS) : n;
      return r;
   endfunction

endpackage

### rtl/core/sdnn_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; a read of the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
module sdnn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/subdomain_node_numbering.sv
// ----------------------------------------------------------------------------
// Subdomain node numbering
// Numbers one mesh node per request; emits one result per owning subdomain,
// or one error result if out of range, with local indices from a counter RAM.
//
//   channel  | ports             | direction | holds
//   ---------+-------------------+-----------+----------------------------
//   request  | req_valid/ready   | in        | subdomain coords, flags
//   response | rsp_valid/ready   | out       | id, indices, error, last
//   csr      | csr_wr_en/index   | in        | subdomain counts x, y, z
//
// A node takes the transfer, a prepare step that builds its partial ids and
// one dispatch step per owning subdomain (1 to 8); the counter RAM's single
// read-modify-write per cycle paces the dispatch. After reset the block
// clears all 512 counter RAM entries and takes no request meanwhile. A
// stalled response holds the write-back stage and with it the dispatcher.
// ----------------------------------------------------------------------------
module subdomain_node_numbering import sdnn_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_payload_type           req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_payload_type           rsp_payload,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_wdata
);

   localparam int ADDR_BITS = $clog2(STORE_DEPTH);

   // Configuration
   logic [CFG_BITS-1:0] dom_x_cnt_ff, dom_y_cnt_ff, dom_z_cnt_ff;
   logic [CFG_BITS-1:0] nx_eff, ny_eff, nz_eff;
   logic [NYZ_BITS-1:0] nyz_ff;

   // Control
   state_type              state_ff, state_in;
   logic [ADDR_BITS-1:0]   clr_addr_ff, clr_addr_in;
   logic [GLOBAL_INDEX_BITS-1:0] node_ctr_ff, node_ctr_in;
   logic [GLOBAL_INDEX_BITS-1:0] iface_ctr_ff, iface_ctr_in;

   // Item being dispatched
   req_payload_type              item_ff;
   logic [NUM_SLOTS-1:0]         pending_ff, pending_in;
   logic                         bad_ff, bad_in;
   logic [PX_BITS-1:0]           px0_ff, px1_ff;
   logic [PY_BITS-1:0]           py0_ff, py1_ff;
   logic [GLOBAL_INDEX_BITS-1:0] node_ff, node_in;
   logic [GLOBAL_INDEX_BITS-1:0] iface_ff, iface_in;
   logic                         prep_load;

   // Write-back stage
   logic                         w_valid_ff, w_valid_in;
   logic [ID_BITS-1:0]           w_id_ff;
   logic                         w_last_ff, w_bad_ff;
   logic                         w_fresh_ff, w_fresh_in;
   logic [LOCAL_INDEX_BITS-1:0]  w_hold_ff, w_hold_in;
   logic [GLOBAL_INDEX_BITS-1:0] w_node_ff, w_iface_ff;
   logic [LOCAL_INDEX_BITS-1:0]  w_cnt;
   logic                         w_go, w_write;

   // Output register
   logic                         out_valid_ff, out_valid_in;
   rsp_payload_type              out_ff;

   // Dispatch
   logic [SLOT_BITS-1:0]         sel_slot;
   logic [NUM_SLOTS-1:0]         sel_mask, rest_mask;
   logic [2:0]                   step;
   logic [PX_BITS-1:0]           id_sum;
   logic [ID_BITS-1:0]           r_id;
   logic                         r_go;
   logic                         cross_x, cross_y, cross_z, bad_pos;

   // RAM ports
   logic                         ram_wr_en;
   logic [ADDR_BITS-1:0]         ram_wr_addr;
   logic [LOCAL_INDEX_BITS-1:0]  ram_wr_data;
   logic [LOCAL_INDEX_BITS-1:0]  ram_rd_data;

   // ------------------------------------------------------------------------
   // Configuration registers and the y-z plane size
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         dom_x_cnt_ff <= CFG_BITS'(1);
         dom_y_cnt_ff <= CFG_BITS'(1);
         dom_z_cnt_ff <= CFG_BITS'(1);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DOMAINS_X: dom_x_cnt_ff <= csr_wdata;
            CSR_DOMAINS_Y: dom_y_cnt_ff <= csr_wdata;
            CSR_DOMAINS_Z: dom_z_cnt_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign nx_eff = eff_count(dom_x_cnt_ff);
   assign ny_eff = eff_count(dom_y_cnt_ff);
   assign nz_eff = eff_count(dom_z_cnt_ff);

   // Registered from the effective y and z counts; read in the prepare state.
   always_ff @(posedge clock) begin
      nyz_ff <= NYZ_BITS'(ny_eff * nz_eff);
   end

   // ------------------------------------------------------------------------
   // Prepare cycle: range check, crossings, partial ids, global numbers
   // ------------------------------------------------------------------------
   assign bad_pos = ({1'b0, item_ff.dom_x} >= nx_eff) ||
                    ({1'b0, item_ff.dom_y} >= ny_eff) ||
                    ({1'b0, item_ff.dom_z} >= nz_eff);
   assign cross_x = item_ff.first_x && (item_ff.dom_x != '0);
   assign cross_y = item_ff.first_y && (item_ff.dom_y != '0);
   assign cross_z = item_ff.first_z && (item_ff.dom_z != '0);

   assign prep_load = (state_ff == ST_PREP);

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_payload;
      end
      if (prep_load) begin
         px0_ff <= PX_BITS'(PX_BITS'(item_ff.dom_x) * PX_BITS'(nyz_ff));
         px1_ff <= PX_BITS'(PX_BITS'(item_ff.dom_x - 1'b1) * PX_BITS'(nyz_ff));
         py0_ff <= PY_BITS'(PY_BITS'(item_ff.dom_y) * PY_BITS'(nz_eff));
         py1_ff <= PY_BITS'(PY_BITS'(item_ff.dom_y - 1'b1) * PY_BITS'(nz_eff));
      end
   end

   // ------------------------------------------------------------------------
   // Dispatch: lowest pending owner slot, its id and the counter read
   // ------------------------------------------------------------------------
   always_comb begin
      sel_slot = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (pending_ff[i]) begin
            sel_slot = SLOT_BITS'(i);
         end
      end
   end

   assign sel_mask  = NUM_SLOTS'(1) << sel_slot;
   assign rest_mask = pending_ff & ~sel_mask;
   assign step      = slot_step(sel_slot);
   assign id_sum    = (step[2] ? px1_ff : px0_ff) +
                      PX_BITS'(step[1] ? py1_ff : py0_ff) +
                      PX_BITS'(step[0] ? item_ff.dom_z - 1'b1 : item_ff.dom_z);
   assign r_id      = id_sum[ID_BITS-1:0];

   assign w_go    = w_valid_ff && (!out_valid_ff || rsp_ready);
   assign w_write = w_go && !w_bad_ff;
   assign r_go    = (state_ff == ST_DISPATCH) && (!w_valid_ff || w_go);

   // ------------------------------------------------------------------------
   // State machine
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         node_ctr_ff  <= '0;
         iface_ctr_ff <= GLOBAL_INDEX_BITS'(1);
         pending_ff   <= '0;
         bad_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         node_ctr_ff  <= node_ctr_in;
         iface_ctr_ff <= iface_ctr_in;
         pending_ff   <= pending_in;
         bad_ff       <= bad_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff  <= node_in;
      iface_ff <= iface_in;
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      node_ctr_in  = node_ctr_ff;
      iface_ctr_in = iface_ctr_ff;
      pending_in   = pending_ff;
      bad_in       = bad_ff;
      node_in      = node_ff;
      iface_in     = iface_ff;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_BITS'(STORE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_DISPATCH;
            bad_in   = bad_pos;
            if (bad_pos) begin
               // A single error result; no counter moves.
               pending_in = NUM_SLOTS'(1);
            end else begin
               pending_in = {cross_x && cross_y && cross_z, cross_x && cross_z,
                             cross_y && cross_x, cross_z && cross_y,
                             cross_x, cross_y, cross_z, 1'b1};
               node_in     = node_ctr_ff;
               node_ctr_in = node_ctr_ff + 1'b1;
               if (cross_x || cross_y || cross_z) begin
                  iface_in     = iface_ctr_ff;
                  iface_ctr_in = iface_ctr_ff + 1'b1;
               end else begin
                  iface_in = '0;
               end
            end
         end
         ST_DISPATCH: begin
            if (r_go) begin
               pending_in = rest_mask;
               if (rest_mask == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // ------------------------------------------------------------------------
   // Write-back stage: counter value, increment, result
   // ------------------------------------------------------------------------
   assign w_cnt = w_fresh_ff ? ram_rd_data : w_hold_ff;

   always_comb begin
      w_valid_in = w_valid_ff;
      w_fresh_in = w_fresh_ff;
      w_hold_in  = w_hold_ff;
      if (r_go) begin
         w_valid_in = 1'b1;
         // The RAM returns the old value when the entry is written in the
         // same cycle, so the new value is forwarded instead.
         if (w_write && (w_id_ff == r_id)) begin
            w_fresh_in = 1'b0;
            w_hold_in  = w_cnt + 1'b1;
         end else begin
            w_fresh_in = 1'b1;
         end
      end else if (w_go) begin
         w_valid_in = 1'b0;
      end else if (w_valid_ff) begin
         // Stalled: keep the value read.
         w_fresh_in = 1'b0;
         w_hold_in  = w_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_valid_ff <= 1'b0;
      end else begin
         w_valid_ff <= w_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_fresh_ff <= w_fresh_in;
      w_hold_ff  <= w_hold_in;
      if (r_go) begin
         w_id_ff    <= r_id;
         w_last_ff  <= (rest_mask == '0);
         w_bad_ff   <= bad_ff;
         w_node_ff  <= node_ff;
         w_iface_ff <= iface_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------------
   always_comb begin
      out_valid_in = out_valid_ff;
      if (w_go) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (w_go) begin
         if (w_bad_ff) begin
            out_ff <= '{domain_id: '0, local_index: '0, node_number: '0,
                        interface_number: '0, bad_position: 1'b1, last: 1'b1};
         end else begin
            out_ff <= '{domain_id: w_id_ff, local_index: w_cnt,
                        node_number: w_node_ff, interface_number: w_iface_ff,
                        bad_position: 1'b0, last: w_last_ff};
         end
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   // ------------------------------------------------------------------------
   // Counter RAM
   // ------------------------------------------------------------------------
   assign ram_wr_en   = (state_ff == ST_CLEAR) || w_write;
   assign ram_wr_addr = (state_ff == ST_CLEAR) ? clr_addr_ff : ADDR_BITS'(w_id_ff);
   assign ram_wr_data = (state_ff == ST_CLEAR) ? '0 : w_cnt + 1'b1;

   sdnn_ram #(
      .WIDTH (LOCAL_INDEX_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_counters (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (r_go),
      .rd_addr (ADDR_BITS'(r_id)),
      .rd_data (ram_rd_data)
   );

endmodule

### tb/sv/tb_subdomain_node_numbering.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for subdomain node numbering
// Sends mesh nodes under several subdomain layouts and checks every owner
// result against a behavioural predictor of the counters and the owner order.
// ----------------------------------------------------------------------------
module tb_subdomain_node_numbering;
   import sdnn_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;

   // Predicts the results of each node and keeps the results still owed.
   class numbering_scoreboard;
      logic [CFG_BITS-1:0]          count_x, count_y, count_z;
      logic [LOCAL_INDEX_BITS-1:0]  local_count [STORE_DEPTH];
      logic [GLOBAL_INDEX_BITS-1:0] node_count;
      logic [GLOBAL_INDEX_BITS-1:0] iface_count;
      rsp_payload_type              owed [$];
      int                           mismatches;

      function new();
         count_x = 1;
         count_y = 1;
         count_z = 1;
         foreach (local_count[i]) local_count[i] = '0;
         node_count = '0;
         iface_count = 1;
         mismatches = 0;
      endfunction

      static function int usable(logic [CFG_BITS-1:0] n);
         return (n > MAX_DOMAINS_PER_AXIS) ? MAX_DOMAINS_PER_AXIS : int'(n);
      endfunction

      function void write_count(logic [CSR_INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] v);
         case (idx)
            CSR_DOMAINS_X: count_x = v;
            CSR_DOMAINS_Y: count_y = v;
            CSR_DOMAINS_Z: count_z = v;
            default: ;
         endcase
      endfunction

      function int waiting();
         return owed.size();
      endfunction

      function void note_node(req_payload_type p);
         int nx, ny, nz, x, y, z, id;
         bit cx, cy, cz;
         int owners [$];
         rsp_payload_type r;
         logic [GLOBAL_INDEX_BITS-1:0] iface, node;
         nx = usable(count_x);
         ny = usable(count_y);
         nz = usable(count_z);
         x = p.dom_x;
         y = p.dom_y;
         z = p.dom_z;
         r = '0;
         if (x >= nx || y >= ny || z >= nz) begin
            // Out-of-range node: a lone error result and no counter moves.
            r.bad_position = 1'b1;
            r.last = 1'b1;
            owed.push_back(r);
            return;
         end
         cx = p.first_x && x != 0;
         cy = p.first_y && y != 0;
         cz = p.first_z && z != 0;
         owners.push_back(x * ny * nz + y * nz + z);
         if (cz) owners.push_back(x * ny * nz + y * nz + z - 1);
         if (cy) owners.push_back(x * ny * nz + (y - 1) * nz + z);
         if (cx) owners.push_back((x - 1) * ny * nz + y * nz + z);
         if (cz && cy) owners.push_back(x * ny * nz + (y - 1) * nz + z - 1);
         if (cy && cx) owners.push_back((x - 1) * ny * nz + (y - 1) * nz + z);
         if (cx && cz) owners.push_back((x - 1) * ny * nz + y * nz + z - 1);
         if (cx && cy && cz) owners.push_back((x - 1) * ny * nz + (y - 1) * nz + z - 1);
         iface = '0;
         if (cx || cy || cz) begin
            iface = iface_count;
            iface_count = iface_count + 1'b1;
         end
         node = node_count;
         node_count = node_count + 1'b1;
         foreach (owners[k]) begin
            id = owners[k] % STORE_DEPTH;
            r.domain_id = ID_BITS'(id);
            r.local_index = local_count[id];
            local_count[id] = local_count[id] + 1'b1;
            r.node_number = node;
            r.interface_number = iface;
            r.bad_position = 1'b0;
            r.last = (k == owners.size() - 1);
            owed.push_back(r);
         end
      endfunction

      function void check_result(rsp_payload_type r);
         rsp_payload_type e;
         if (owed.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected result: id %0d local %0d node %0d iface %0d bad %0b last %0b",
                        r.domain_id, r.local_index, r.node_number, r.interface_number,
                        r.bad_position, r.last);
            mismatches++;
            return;
         end
         e = owed.pop_front();
         if (r.domain_id !== e.domain_id || r.local_index !== e.local_index ||
             r.node_number !== e.node_number || r.interface_number !== e.interface_number ||
             r.bad_position !== e.bad_position || r.last !== e.last) begin
            if (mismatches < 10) begin
               $display("result mismatch at %0t", $realtime);
               $display("  expected id %0d local %0d node %0d iface %0d bad %0b last %0b",
                        e.domain_id, e.local_index, e.node_number, e.interface_number,
                        e.bad_position, e.last);
               $display("  actual   id %0d local %0d node %0d iface %0d bad %0b last %0b",
                        r.domain_id, r.local_index, r.node_number, r.interface_number,
                        r.bad_position, r.last);
            end
            mismatches++;
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   req_payload_type           req_payload;
   logic                      rsp_valid;
   logic                      rsp_ready;
   rsp_payload_type           rsp_payload;
   logic                      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CFG_BITS-1:0]       csr_wdata;

   numbering_scoreboard sb;
   req_payload_type     node_batch [$];
   int                  cycle_count = 0;

   subdomain_node_numbering u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_subdomain_node_numbering: FAIL");
         $finish;
      end
   end

   // Both transfers are observed on the edge at which they happen.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_node(req_payload);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_payload);
      end
   end

   // Receiver: switches among random stall modes, from always ready to mostly stalled.
   initial begin
      int mode;
      int tick;
      mode = 0;
      tick = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (tick % 40 == 0) mode = $urandom_range(0, 3);
         tick++;
         case (mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (tick % 5 < 2);
         endcase
      end
   end

   function automatic req_payload_type make_node(int x, int y, int z, logic [2:0] flags);
      req_payload_type p;
      p.dom_x = COORD_BITS'(x);
      p.dom_y = COORD_BITS'(y);
      p.dom_z = COORD_BITS'(z);
      {p.first_x, p.first_y, p.first_z} = flags;
      return p;
   endfunction

   // Mostly nodes inside the current layout, the rest anywhere in the field range.
   function automatic req_payload_type random_node();
      int nx, ny, nz;
      logic [2:0] flags;
      nx = numbering_scoreboard::usable(sb.count_x);
      ny = numbering_scoreboard::usable(sb.count_y);
      nz = numbering_scoreboard::usable(sb.count_z);
      flags = {$urandom_range(0, 2) != 0, $urandom_range(0, 2) != 0,
               $urandom_range(0, 2) != 0};
      if ($urandom_range(0, 99) < 85 && nx > 0 && ny > 0 && nz > 0)
         return make_node($urandom_range(0, nx - 1), $urandom_range(0, ny - 1),
                          $urandom_range(0, nz - 1), flags);
      return make_node($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7),
                       flags);
   endfunction

   task automatic send_node(input req_payload_type p);
      req_valid <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (!req_ready);
   endtask

   // Sends node_batch in bursts; valid drops only between bursts.
   task automatic send_batch();
      int burst_left;
      int gap;
      burst_left = $urandom_range(1, 12);
      foreach (node_batch[i]) begin
         send_node(node_batch[i]);
         burst_left--;
         if (burst_left == 0 || i == node_batch.size() - 1) begin
            gap = $urandom_range(1, 9);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
            burst_left = $urandom_range(1, 12);
         end
      end
      node_batch.delete();
   endtask

   // Waits for the block to drain, then sets the three counts and pokes the
   // unused index, which must change nothing.
   task automatic set_layout(input logic [CFG_BITS-1:0] nx, input logic [CFG_BITS-1:0] ny,
                             input logic [CFG_BITS-1:0] nz);
      logic [CSR_INDEX_BITS-1:0] idx [4];
      logic [CFG_BITS-1:0]       val [4];
      idx = '{CSR_DOMAINS_X, CSR_DOMAINS_Y, CSR_DOMAINS_Z, CSR_UNUSED};
      val = '{nx, ny, nz, CFG_BITS'($urandom_range(0, 15))};
      while (sb.waiting() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      for (int i = 0; i < 4; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         sb.write_count(idx[i], val[i]);
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      logic [CFG_BITS-1:0] cnt [3];
      int r;
      sb = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_DOMAINS_X;
      csr_wdata <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Full layout: the origin, the far corner, every face, edge and corner
      // owner, and a crossing flag on a zero coordinate that must not count.
      set_layout(8, 8, 8);
      node_batch.push_back(make_node(0, 0, 0, 3'b111));
      node_batch.push_back(make_node(7, 7, 7, 3'b111));
      node_batch.push_back(make_node(7, 7, 7, 3'b000));
      node_batch.push_back(make_node(4, 3, 2, 3'b001));
      node_batch.push_back(make_node(4, 3, 2, 3'b010));
      node_batch.push_back(make_node(4, 3, 2, 3'b100));
      node_batch.push_back(make_node(4, 3, 2, 3'b011));
      node_batch.push_back(make_node(4, 3, 2, 3'b110));
      node_batch.push_back(make_node(4, 3, 2, 3'b101));
      node_batch.push_back(make_node(4, 3, 2, 3'b111));
      node_batch.push_back(make_node(0, 5, 6, 3'b111));
      send_batch();

      // Counts above the maximum behave as the maximum.
      set_layout(15, 9, 12);
      node_batch.push_back(make_node(7, 7, 7, 3'b111));
      node_batch.push_back(make_node(7, 0, 7, 3'b111));
      send_batch();

      // Uneven layout with each coordinate just out of range.
      set_layout(3, 5, 2);
      node_batch.push_back(make_node(3, 0, 0, 3'b000));
      node_batch.push_back(make_node(0, 5, 0, 3'b000));
      node_batch.push_back(make_node(0, 0, 2, 3'b111));
      node_batch.push_back(make_node(2, 4, 1, 3'b111));
      node_batch.push_back(make_node(1, 2, 1, 3'b110));
      send_batch();

      // Zero counts reject every node.
      set_layout(0, 0, 0);
      node_batch.push_back(make_node(0, 0, 0, 3'b000));
      node_batch.push_back(make_node(0, 0, 0, 3'b111));
      send_batch();

      set_layout(1, 1, 1);
      node_batch.push_back(make_node(0, 0, 0, 3'b111));
      node_batch.push_back(make_node(1, 1, 1, 3'b111));
      send_batch();

      // Random layouts; the first is the full one.
      for (int phase = 0; phase < 5; phase++) begin
         for (int a = 0; a < 3; a++) begin
            r = $urandom_range(0, 9);
            if (phase == 0) cnt[a] = 8;
            else if (r < 8) cnt[a] = CFG_BITS'($urandom_range(2, 8));
            else if (r == 8) cnt[a] = CFG_BITS'($urandom_range(9, 15));
            else cnt[a] = 1;
         end
         set_layout(cnt[0], cnt[1], cnt[2]);
         for (int i = 0; i < 22; i++) node_batch.push_back(random_node());
         send_batch();
      end

      while (sb.waiting() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.waiting() == 0)
         $display("tb_subdomain_node_numbering: PASS");
      else
         $display("tb_subdomain_node_numbering: FAIL");
      $finish;
   end

endmodule
